// ===== sv/cwft_pkg.sv =====
// ---------------------------------------------------------------------------
// cwft_pkg
// Shared widths, codes and defaults for the cursor and window focus tracker.
// ---------------------------------------------------------------------------
package cwft_pkg;

	// Default sizes of the window table and of process ids.
	localparam int MAX_WINDOWS_DEF = 16;
	localparam int ID_BITS_DEF     = 16;

	// Field widths.
	localparam int KIND_W   = 2;
	localparam int DELTA_W  = 16;
	localparam int BTN_W    = 8;
	localparam int POS_W    = 12;
	localparam int EDGE_W   = 13;
	localparam int SIZE_W   = 13;
	localparam int STATUS_W = 3;
	localparam int REP_W    = 14;
	localparam int CFG_IDX_W = 1;

	// Screen size limits and reset values.
	localparam logic [SIZE_W-1:0] SCREEN_MAX     = 13'd4096;
	localparam logic [SIZE_W-1:0] SCREEN_W_RESET = 13'd1024;
	localparam logic [SIZE_W-1:0] SCREEN_H_RESET = 13'd768;

	// Cursor reset position.
	localparam logic [POS_W-1:0] CURSOR_X_RESET = 12'd512;
	localparam logic [POS_W-1:0] CURSOR_Y_RESET = 12'd384;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

	// Input item kinds.
	localparam logic [KIND_W-1:0] KIND_MOUSE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MOVE     = 2'd2;
	localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_DONE  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BLANK = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABS   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_REL   = 3'd4;

endpackage

// ===== sv/cwft_clamp.sv =====
// ---------------------------------------------------------------------------
// cwft_clamp
// Moves one cursor axis by a signed delta and clamps it to the screen.
// ---------------------------------------------------------------------------
module cwft_clamp (
	input  logic [cwft_pkg::POS_W-1:0]          pos,
	input  logic signed [cwft_pkg::DELTA_W-1:0] delta,
	input  logic [cwft_pkg::SIZE_W-1:0]         size,
	output logic [cwft_pkg::POS_W-1:0]          pos_next
);
	import cwft_pkg::*;

	localparam int SUM_W = DELTA_W + 2;

	logic [SIZE_W-1:0]       size_eff;
	logic [POS_W-1:0]        lim;
	logic signed [SUM_W-1:0] sum;

	// The screen size register is bounded to 1..4096 before use.
	always_comb begin
		if (size == '0) begin
			size_eff = SIZE_W'(1);
		end else if (size > SCREEN_MAX) begin
			size_eff = SCREEN_MAX;
		end else begin
			size_eff = size;
		end
	end

	assign lim = POS_W'(size_eff - SIZE_W'(1));
	assign sum = signed'({{(SUM_W-POS_W){1'b0}}, pos}) + SUM_W'(delta);

	// Clamp the new position to zero and the last pixel.
	always_comb begin
		if (sum < 0) begin
			pos_next = '0;
		end else if (sum > signed'({{(SUM_W-POS_W){1'b0}}, lim})) begin
			pos_next = lim;
		end else begin
			pos_next = sum[POS_W-1:0];
		end
	end

endmodule

// ===== sv/cwft_table.sv =====
// ---------------------------------------------------------------------------
// cwft_table
// Window table memory: one write port and one read port, registered read.
// ---------------------------------------------------------------------------
module cwft_table #(
	parameter int DEPTH  = cwft_pkg::MAX_WINDOWS_DEF,
	parameter int DATA_W = 8,
	parameter int ADDR_W = 4
) (
	input  logic              clk,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Synchronous write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/cwft_seq.sv =====
// ---------------------------------------------------------------------------
// cwft_seq
// Sequencer: holds cursor and focus state, scans the window table through
// its read port, writes entries back and registers the result word.
// ---------------------------------------------------------------------------
module cwft_seq #(
	parameter int MAX_WINDOWS = cwft_pkg::MAX_WINDOWS_DEF,
	parameter int ID_BITS     = cwft_pkg::ID_BITS_DEF,
	parameter int IDX_W       = 4,
	parameter int ENTRY_W     = 66
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic [cwft_pkg::SIZE_W-1:0]          screen_width,
	input  logic [cwft_pkg::SIZE_W-1:0]          screen_height,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [cwft_pkg::KIND_W-1:0]          kind,
	input  logic signed [cwft_pkg::DELTA_W-1:0]  delta_x,
	input  logic signed [cwft_pkg::DELTA_W-1:0]  delta_y,
	input  logic [cwft_pkg::BTN_W-1:0]           button_bits,
	input  logic [ID_BITS-1:0]                   owner_id,
	input  logic [cwft_pkg::POS_W-1:0]           win_left,
	input  logic [cwft_pkg::POS_W-1:0]           win_top,
	input  logic [cwft_pkg::POS_W-1:0]           win_width,
	input  logic [cwft_pkg::POS_W-1:0]           win_height,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [cwft_pkg::STATUS_W-1:0]        status,
	output logic signed [cwft_pkg::REP_W-1:0]    report_x,
	output logic signed [cwft_pkg::REP_W-1:0]    report_y,
	output logic [cwft_pkg::BTN_W-1:0]           report_buttons,
	output logic [ID_BITS-1:0]                   focused_id,
	output logic                                 rd_en,
	output logic [IDX_W-1:0]                     rd_addr,
	input  logic [ENTRY_W-1:0]                   rd_data,
	output logic                                 wr_en,
	output logic [IDX_W-1:0]                     wr_addr,
	output logic [ENTRY_W-1:0]                   wr_data
);
	import cwft_pkg::*;

	localparam int CNT_W = $clog2(MAX_WINDOWS + 1);

	typedef struct packed {
		logic [ID_BITS-1:0] owner;
		logic [POS_W-1:0]   left;
		logic [POS_W-1:0]   top;
		logic [EDGE_W-1:0]  right;
		logic [EDGE_W-1:0]  bottom;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FIN
	} state_t;

	state_t state_q;

	// Architectural state.
	logic [CNT_W-1:0]   count_q;
	logic [POS_W-1:0]   cursor_x_q;
	logic [POS_W-1:0]   cursor_y_q;
	logic [BTN_W-1:0]   buttons_q;
	logic [ID_BITS-1:0] focus_q;

	// Item being worked on.
	logic [KIND_W-1:0]  kind_q;
	logic [ID_BITS-1:0] id_q;
	logic [POS_W-1:0]   left_q;
	logic [POS_W-1:0]   top_q;
	logic [POS_W-1:0]   wid_q;
	logic [POS_W-1:0]   hgt_q;
	logic               skip_q;

	// Scan control and the entry that matched.
	logic               down_q;
	logic [IDX_W-1:0]   ptr_q;
	logic [CNT_W-1:0]   issue_left_q;
	logic               rd_pend_q;
	logic               rd_last_q;
	logic [IDX_W-1:0]   rd_idx_q;
	logic               found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	entry_t             hit_q;

	// Result word register.
	logic                     result_valid_q;
	logic [STATUS_W-1:0]      status_q;
	logic signed [REP_W-1:0]  report_x_q;
	logic signed [REP_W-1:0]  report_y_q;
	logic [BTN_W-1:0]         report_buttons_q;
	logic [ID_BITS-1:0]       focused_id_q;

	logic [POS_W-1:0]   nx;
	logic [POS_W-1:0]   ny;
	entry_t             rd_entry;
	entry_t             wr_entry;
	logic               accept;
	logic               full;
	logic               skip_in;
	logic               match;
	logic               issue;
	logic               fin_go;
	logic [STATUS_W-1:0]     res_status;
	logic signed [REP_W-1:0] res_x;
	logic signed [REP_W-1:0] res_y;
	logic [BTN_W-1:0]        res_buttons;
	logic [ID_BITS-1:0]      res_focus;

	// Cursor movement for a mouse word.
	cwft_clamp u_clamp_x (
		.pos      (cursor_x_q),
		.delta    (delta_x),
		.size     (screen_width),
		.pos_next (nx)
	);

	cwft_clamp u_clamp_y (
		.pos      (cursor_y_q),
		.delta    (delta_y),
		.size     (screen_height),
		.pos_next (ny)
	);

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign full       = (count_q >= CNT_W'(MAX_WINDOWS));
	assign rd_entry   = entry_t'(rd_data);

	// A register word on a full table and a query from an unfocused id need no lookup.
	assign skip_in = ((kind == KIND_REGISTER) && full) ||
		((kind == KIND_QUERY) && (owner_id != focus_q));

	// A mouse word hit-tests the cursor; other kinds look up the id.
	always_comb begin
		if (kind_q == KIND_MOUSE) begin
			match = (cursor_x_q >= rd_entry.left) &&
				({1'b0, cursor_x_q} <= rd_entry.right) &&
				(cursor_y_q >= rd_entry.top) &&
				({1'b0, cursor_y_q} <= rd_entry.bottom);
		end else begin
			match = (rd_entry.owner == id_q);
		end
	end

	// Reads are issued one per cycle; issuing stops once the scan ends.
	assign issue = (state_q == S_SCAN) && (issue_left_q != '0) &&
		!(rd_pend_q && (match || rd_last_q));
	assign rd_en   = issue;
	assign rd_addr = ptr_q;

	// The finished word leaves once the result register is free.
	assign fin_go = (state_q == S_FIN) && (!result_valid_q || !result_stall);

	// Write back a registered or moved window.
	always_comb begin
		wr_entry.owner = id_q;
		wr_entry.left  = left_q;
		wr_entry.top   = top_q;
		if (kind_q == KIND_REGISTER) begin
			wr_entry.right  = {1'b0, left_q} + {1'b0, wid_q};
			wr_entry.bottom = {1'b0, top_q} + {1'b0, hgt_q};
		end else begin
			wr_entry.right  = {1'b0, left_q} + (hit_q.right - {1'b0, hit_q.left});
			wr_entry.bottom = {1'b0, top_q} + (hit_q.bottom - {1'b0, hit_q.top});
		end
	end

	assign wr_en = fin_go && (((kind_q == KIND_REGISTER) && !skip_q) ||
		((kind_q == KIND_MOVE) && found_q));
	assign wr_addr = found_q ? hit_idx_q : IDX_W'(count_q);
	assign wr_data = ENTRY_W'(wr_entry);

	// Result fields for the item in the final step.
	always_comb begin
		res_status  = ST_DONE;
		res_x       = REP_W'({2'b00, cursor_x_q});
		res_y       = REP_W'({2'b00, cursor_y_q});
		res_buttons = buttons_q;
		res_focus   = focus_q;
		case (kind_q)
			KIND_MOUSE: begin
				res_focus = found_q ? hit_q.owner : '0;
			end
			KIND_REGISTER: begin
				res_status = skip_q ? ST_FULL : ST_DONE;
			end
			KIND_QUERY: begin
				if (skip_q) begin
					res_status  = ST_BLANK;
					res_x       = '0;
					res_y       = '0;
					res_buttons = '0;
				end else if (found_q) begin
					res_status = ST_REL;
					res_x      = REP_W'({2'b00, cursor_x_q}) - REP_W'({2'b00, hit_q.left});
					res_y      = REP_W'({2'b00, cursor_y_q}) - REP_W'({2'b00, hit_q.top});
				end else begin
					res_status = ST_ABS;
				end
			end
			default: begin
			end
		endcase
	end

	// State machine, architectural state and the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			count_q        <= '0;
			cursor_x_q     <= CURSOR_X_RESET;
			cursor_y_q     <= CURSOR_Y_RESET;
			buttons_q      <= '0;
			focus_q        <= '0;
			rd_pend_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= issue;
			if (fin_go) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q       <= kind;
						id_q         <= owner_id;
						left_q       <= win_left;
						top_q        <= win_top;
						wid_q        <= win_width;
						hgt_q        <= win_height;
						found_q      <= 1'b0;
						skip_q       <= skip_in;
						down_q       <= (kind == KIND_MOUSE);
						ptr_q        <= (kind == KIND_MOUSE) ?
							IDX_W'(count_q - CNT_W'(1)) : '0;
						issue_left_q <= count_q;
						state_q      <= (skip_in || (count_q == '0)) ? S_FIN : S_SCAN;
						if (kind == KIND_MOUSE) begin
							cursor_x_q <= nx;
							cursor_y_q <= ny;
							buttons_q  <= button_bits;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q        <= down_q ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
						issue_left_q <= issue_left_q - CNT_W'(1);
						rd_last_q    <= (issue_left_q == CNT_W'(1));
						rd_idx_q     <= ptr_q;
					end
					if (rd_pend_q) begin
						if (match) begin
							found_q   <= 1'b1;
							hit_idx_q <= rd_idx_q;
							hit_q     <= rd_entry;
							state_q   <= S_FIN;
						end else if (rd_last_q) begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (fin_go) begin
						status_q         <= res_status;
						report_x_q       <= res_x;
						report_y_q       <= res_y;
						report_buttons_q <= res_buttons;
						focused_id_q     <= res_focus;
						focus_q          <= res_focus;
						if ((kind_q == KIND_REGISTER) && !skip_q && !found_q) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign status         = status_q;
	assign report_x       = report_x_q;
	assign report_y       = report_y_q;
	assign report_buttons = report_buttons_q;
	assign focused_id     = focused_id_q;

endmodule

// ===== sv/cursor_window_focus_tracker_unit.sv =====
// ---------------------------------------------------------------------------
// cursor_window_focus_tracker_unit
// Hardware cursor and window focus tracker with a memory-based window table.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  item      item_valid / item_stall   kind, delta_x, delta_y, button_bits,
//                                      owner_id, win_left, win_top,
//                                      win_width, win_height
//  result    result_valid / result_stall  status, report_x, report_y,
//                                      report_buttons, focused_id
//  config    cfg_we                    cfg_index, cfg_data
//
// With the result register free, an item passes from acceptance to the next
// acceptance through the scan and fin states, reading table entries until one
// matches or all have been read. The table read port delivers one entry per
// cycle. Items that need no lookup (empty table, register word on a full
// table, blanked query) go from idle straight to the fin state.
// Reset clears the window count, focus and buttons and centers the cursor.
// A stalled result word holds in the result register while the next item
// is taken and scanned; it waits only to hand over its own result.
// ---------------------------------------------------------------------------
module cursor_window_focus_tracker_unit #(
	parameter int MAX_WINDOWS = cwft_pkg::MAX_WINDOWS_DEF,
	parameter int ID_BITS     = cwft_pkg::ID_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [cwft_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cwft_pkg::SIZE_W-1:0]          cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_stall,
	input  logic [cwft_pkg::KIND_W-1:0]          kind,
	input  logic signed [cwft_pkg::DELTA_W-1:0]  delta_x,
	input  logic signed [cwft_pkg::DELTA_W-1:0]  delta_y,
	input  logic [cwft_pkg::BTN_W-1:0]           button_bits,
	input  logic [ID_BITS-1:0]                   owner_id,
	input  logic [cwft_pkg::POS_W-1:0]           win_left,
	input  logic [cwft_pkg::POS_W-1:0]           win_top,
	input  logic [cwft_pkg::POS_W-1:0]           win_width,
	input  logic [cwft_pkg::POS_W-1:0]           win_height,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [cwft_pkg::STATUS_W-1:0]        status,
	output logic signed [cwft_pkg::REP_W-1:0]    report_x,
	output logic signed [cwft_pkg::REP_W-1:0]    report_y,
	output logic [cwft_pkg::BTN_W-1:0]           report_buttons,
	output logic [ID_BITS-1:0]                   focused_id
);
	import cwft_pkg::*;

	localparam int IDX_W   = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int ENTRY_W = ID_BITS + 2 * POS_W + 2 * EDGE_W;

	logic [SIZE_W-1:0]  screen_width_q;
	logic [SIZE_W-1:0]  screen_height_q;
	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	logic [ENTRY_W-1:0] rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	logic [ENTRY_W-1:0] wr_data;

	// Screen size registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= SCREEN_W_RESET;
			screen_height_q <= SCREEN_H_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer.
	cwft_seq #(
		.MAX_WINDOWS (MAX_WINDOWS),
		.ID_BITS     (ID_BITS),
		.IDX_W       (IDX_W),
		.ENTRY_W     (ENTRY_W)
	) u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.screen_width   (screen_width_q),
		.screen_height  (screen_height_q),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.kind           (kind),
		.delta_x        (delta_x),
		.delta_y        (delta_y),
		.button_bits    (button_bits),
		.owner_id       (owner_id),
		.win_left       (win_left),
		.win_top        (win_top),
		.win_width      (win_width),
		.win_height     (win_height),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.status         (status),
		.report_x       (report_x),
		.report_y       (report_y),
		.report_buttons (report_buttons),
		.focused_id     (focused_id),
		.rd_en          (rd_en),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.wr_en          (wr_en),
		.wr_addr        (wr_addr),
		.wr_data        (wr_data)
	);

	// Window table.
	cwft_table #(
		.DEPTH  (MAX_WINDOWS),
		.DATA_W (ENTRY_W),
		.ADDR_W (IDX_W)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

endmodule

// ===== sv/cwft_checker.sv =====
// ---------------------------------------------------------------------------
// cwft_checker
// Port-level assertions for the focus tracker, bound to the top level.
// ---------------------------------------------------------------------------
module cwft_checker #(
	parameter int ID_BITS = cwft_pkg::ID_BITS_DEF
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic                              result_valid,
	input logic                              result_stall,
	input logic [cwft_pkg::STATUS_W-1:0]     status,
	input logic signed [cwft_pkg::REP_W-1:0] report_x,
	input logic signed [cwft_pkg::REP_W-1:0] report_y,
	input logic [cwft_pkg::BTN_W-1:0]        report_buttons,
	input logic [ID_BITS-1:0]                focused_id
);
	import cwft_pkg::*;

	// A stalled result word stays and holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) &&
		$stable(report_x) && $stable(report_y) && $stable(report_buttons) &&
		$stable(focused_id))
		else $error("result word changed while stalled");

	// Only one item is worked on at a time.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("item taken while another is in progress");

	// Status codes stay within the defined set.
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= ST_REL)
		else $error("undefined status code");

	// A blanked query reports nothing.
	a_blank_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (status == ST_BLANK) |->
		(report_x == '0) && (report_y == '0) && (report_buttons == '0))
		else $error("blanked query carries data");

endmodule

bind cursor_window_focus_tracker_unit cwft_checker #(
	.ID_BITS (ID_BITS)
) u_cwft_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_stall     (item_stall),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.status         (status),
	.report_x       (report_x),
	.report_y       (report_y),
	.report_buttons (report_buttons),
	.focused_id     (focused_id)
);
